// ===== rtl/core/mhs_pkg.sv =====
`timescale 1ns / 1ps

package mhs_pkg;

    // field widths
    localparam int DEG_W     = 9;
    localparam int MAG_W     = 16;
    localparam int PRE_SHIFT = 20;
    // cordic datapath: magnitude, pre-shift, gain headroom and sign
    localparam int XW        = MAG_W + PRE_SHIFT + 2;

    localparam int TABLE_BITS = 24;
    localparam int TABLE_LEN  = 28;

    localparam logic [DEG_W-1:0] HEADING_TURN = 9'd360;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [31:0] ATAN_Q24 [0:TABLE_LEN-1] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,
        32'd57,        32'd29,        32'd14,        32'd7
    };

    // table entry brought to afb fraction bits, rounded half up
    function automatic logic [31:0] atan_entry(input int idx, input int afb);
        logic [31:0] t;
        int          drop;
        t    = ATAN_Q24[idx];
        drop = TABLE_BITS - afb;
        if (drop <= 0) begin
            return t;
        end
        return ((t >> (drop - 1)) + 32'd1) >> 1;
    endfunction

    // octant folding flags carried alongside the cordic
    typedef struct packed {
        logic zero;
        logic on_axis;
        logic diag;
        logic swapped;
        logic neg_x;
        logic neg_y;
    } side_t;

    typedef struct packed {
        logic             safe;
        logic [DEG_W-1:0] degree;
        logic [DEG_W-1:0] index;
        logic [DEG_W-1:0] heading;
    } res_t;

endpackage

// ===== rtl/core/magnetic_heading_sectorizer.sv =====
`timescale 1ns / 1ps

// magnetic heading sectorizer
// s_ channel: one word per magnetometer reading, x and y signed 16 bit.
// m_ channel: one word per reading, in order: heading 0..359 from
//   atan2(y, x) truncated toward zero and wrapped, the section number
//   heading / section_width, the degree within the section and a safe
//   flag set when that degree lies strictly between safe_low and safe_high.
// apb port: section_width at 0x0, safe_low at 0x4, safe_high at 0x8,
//   write them only while no reading is in flight.
// pipeline: the fold register, one cordic stage per iteration, then two
//   heading stages, nine divider stages with their result register and
//   the output register.
// throughput: one word per cycle, back to back, as long as m_tready is high.
// stall: a full output register and one skid word absorb a stalled
//   receiver; s_tready drops only once the skid word is filled, and the
//   whole pipeline then holds in place until the skid word moves to the output.
// reset: synchronous, active low; clears all valid bits and loads the
//   registers with width 20, low bound 6, high bound 13.

module magnetic_heading_sectorizer #(
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mag_x [15:0], mag_y [31:16]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // heading_deg [8:0], section_index [17:9],
                                   // degree_in_section [26:18], section_safe [27]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AFB = ANGLE_FRACTION_BITS;
    localparam int DW  = mhs_pkg::DEG_W;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SECTION_WIDTH = 2'd0;
    localparam logic [1:0] REG_SAFE_LOW      = 2'd1;
    localparam logic [1:0] REG_SAFE_HIGH     = 2'd2;

    localparam logic [DW-1:0] RST_SECTION_WIDTH = 9'd20;
    localparam logic [DW-1:0] RST_SAFE_LOW      = 9'd6;
    localparam logic [DW-1:0] RST_SAFE_HIGH     = 9'd13;

    // configuration registers
    logic [DW-1:0] section_width_reg;
    logic [DW-1:0] safe_low_reg;
    logic [DW-1:0] safe_high_reg;
    logic [1:0]    reg_sel;
    logic          cfg_wr;

    // pipeline control: everything moves unless the skid word is occupied
    logic adv;

    logic                          fold_valid;
    mhs_pkg::side_t                fold_side;
    logic signed [mhs_pkg::XW-1:0] fold_x;
    logic signed [mhs_pkg::XW-1:0] fold_y;

    logic                          cor_valid;
    mhs_pkg::side_t                cor_side;
    logic signed [AFB+8:0]         cor_z;

    logic                          head_valid;
    logic [DW-1:0]                 head_deg;

    logic                          pipe_valid;
    mhs_pkg::res_t                 pipe_res;
    logic                          push;

    // output register and skid word
    logic          out_valid_reg;
    logic          out_valid_next;
    mhs_pkg::res_t out_res_reg;
    mhs_pkg::res_t out_res_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    mhs_pkg::res_t skid_res_reg;
    mhs_pkg::res_t skid_res_next;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_width_reg <= RST_SECTION_WIDTH;
            safe_low_reg      <= RST_SAFE_LOW;
            safe_high_reg     <= RST_SAFE_HIGH;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_SECTION_WIDTH: section_width_reg <= pwdata[DW-1:0];
                REG_SAFE_LOW:      safe_low_reg      <= pwdata[DW-1:0];
                REG_SAFE_HIGH:     safe_high_reg     <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SECTION_WIDTH: prdata = {{(32 - DW){1'b0}}, section_width_reg};
            REG_SAFE_LOW:      prdata = {{(32 - DW){1'b0}}, safe_low_reg};
            REG_SAFE_HIGH:     prdata = {{(32 - DW){1'b0}}, safe_high_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // fold the reading into the first octant
    mhs_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .mag_x     (s_tdata[15:0]),
        .mag_y     (s_tdata[31:16]),
        .out_valid (fold_valid),
        .out_side  (fold_side),
        .out_x     (fold_x),
        .out_y     (fold_y)
    );

    // octant angle, one cordic iteration per stage
    mhs_cordic #(
        .AFB (AFB)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fold_valid),
        .in_side   (fold_side),
        .in_x      (fold_x),
        .in_y      (fold_y),
        .out_valid (cor_valid),
        .out_side  (cor_side),
        .out_z     (cor_z)
    );

    // full-circle integer heading
    mhs_heading #(
        .AFB (AFB)
    ) u_heading (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (cor_valid),
        .in_side     (cor_side),
        .in_z        (cor_z),
        .out_valid   (head_valid),
        .out_heading (head_deg)
    );

    // section number, remainder and safe flag
    mhs_divider u_divider (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (head_valid),
        .in_heading    (head_deg),
        .section_width (section_width_reg),
        .safe_low      (safe_low_reg),
        .safe_high     (safe_high_reg),
        .out_valid     (pipe_valid),
        .out_res       (pipe_res)
    );

    // the last stage hands its word over whenever the pipeline moves
    assign push = pipe_valid && adv;

    // ---------------- output register with skid ----------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                // skid word goes first, pipeline is held meanwhile
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_res_next   = pipe_res;
            end
        end else if (push) begin
            // receiver stalled: park the arriving word
            skid_valid_next = 1'b1;
            skid_res_next   = pipe_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.safe, out_res_reg.degree,
                       out_res_reg.index, out_res_reg.heading};

endmodule

// ===== rtl/core/mhs_fold.sv =====
`timescale 1ns / 1ps

module mhs_fold (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic signed [mhs_pkg::MAG_W-1:0] mag_x,
    input  logic signed [mhs_pkg::MAG_W-1:0] mag_y,
    output logic                             out_valid,
    output mhs_pkg::side_t                   out_side,
    output logic signed [mhs_pkg::XW-1:0]    out_x,
    output logic signed [mhs_pkg::XW-1:0]    out_y
);

    localparam int PAD_W = mhs_pkg::XW - mhs_pkg::MAG_W - mhs_pkg::PRE_SHIFT;

    logic [mhs_pkg::MAG_W-1:0]     ax;
    logic [mhs_pkg::MAG_W-1:0]     by;
    logic [mhs_pkg::MAG_W-1:0]     a;
    logic [mhs_pkg::MAG_W-1:0]     b;
    logic                          swap;
    mhs_pkg::side_t                side_next;
    logic signed [mhs_pkg::XW-1:0] x_next;
    logic signed [mhs_pkg::XW-1:0] y_next;

    logic                          valid_reg;
    mhs_pkg::side_t                side_reg;
    logic signed [mhs_pkg::XW-1:0] x_reg;
    logic signed [mhs_pkg::XW-1:0] y_reg;

    // magnitudes; the most negative reading becomes 32768 unsigned
    assign ax   = mag_x[mhs_pkg::MAG_W-1] ? (~mag_x + 16'd1) : mag_x;
    assign by   = mag_y[mhs_pkg::MAG_W-1] ? (~mag_y + 16'd1) : mag_y;
    assign swap = by > ax;
    assign a    = swap ? by : ax;
    assign b    = swap ? ax : by;

    always_comb begin
        side_next.zero    = (ax == '0) && (by == '0);
        side_next.on_axis = (b == '0);
        side_next.diag    = (a == b);
        side_next.swapped = swap;
        side_next.neg_x   = mag_x[mhs_pkg::MAG_W-1];
        side_next.neg_y   = mag_y[mhs_pkg::MAG_W-1];
        x_next = $signed({{PAD_W{1'b0}}, a, {mhs_pkg::PRE_SHIFT{1'b0}}});
        y_next = $signed({{PAD_W{1'b0}}, b, {mhs_pkg::PRE_SHIFT{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

// ===== rtl/core/mhs_cordic.sv =====
`timescale 1ns / 1ps

module mhs_cordic #(
    parameter int AFB = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  mhs_pkg::side_t                in_side,
    input  logic signed [mhs_pkg::XW-1:0] in_x,
    input  logic signed [mhs_pkg::XW-1:0] in_y,
    output logic                          out_valid,
    output mhs_pkg::side_t                out_side,
    output logic signed [AFB+8:0]         out_z
);

    localparam int STEPS = (AFB + 4 > mhs_pkg::TABLE_LEN) ? mhs_pkg::TABLE_LEN : AFB + 4;
    localparam int ZW    = AFB + 9;
    localparam int XW    = mhs_pkg::XW;

    logic                 v_s    [0:STEPS];
    mhs_pkg::side_t       side_s [0:STEPS];
    logic signed [ZW-1:0] z_s    [0:STEPS];
    logic signed [XW-1:0] x_s    [0:STEPS-1];
    logic signed [XW-1:0] y_s    [0:STEPS-1];

    assign v_s[0]    = in_valid;
    assign side_s[0] = in_side;
    assign z_s[0]    = '0;
    assign x_s[0]    = in_x;
    assign y_s[0]    = in_y;

    // one vectoring iteration per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [ZW-1:0] ANG = ZW'(mhs_pkg::atan_entry(i, AFB));

        logic                 y_pos;
        logic signed [ZW-1:0] z_next;
        logic                 v_reg;
        mhs_pkg::side_t       side_reg;
        logic signed [ZW-1:0] z_reg;

        assign y_pos  = !y_s[i][XW-1];
        assign z_next = y_pos ? (z_s[i] + ANG) : (z_s[i] - ANG);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (adv) begin
                v_reg <= v_s[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg <= side_s[i];
                z_reg    <= z_next;
            end
        end

        assign v_s[i+1]    = v_reg;
        assign side_s[i+1] = side_reg;
        assign z_s[i+1]    = z_reg;

        if (i < STEPS - 1) begin : g_xy
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            logic signed [XW-1:0] x_next;
            logic signed [XW-1:0] y_next;
            logic signed [XW-1:0] x_reg;
            logic signed [XW-1:0] y_reg;

            // arithmetic shift floors negative values
            assign xs = x_s[i] >>> i;
            assign ys = y_s[i] >>> i;

            always_comb begin
                if (y_pos) begin
                    x_next = x_s[i] + ys;
                    y_next = y_s[i] - xs;
                end else begin
                    x_next = x_s[i] - ys;
                    y_next = y_s[i] + xs;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                end
            end

            assign x_s[i+1] = x_reg;
            assign y_s[i+1] = y_reg;
        end
    end

    assign out_valid = v_s[STEPS];
    assign out_side  = side_s[STEPS];
    assign out_z     = z_s[STEPS];

endmodule

// ===== rtl/core/mhs_heading.sv =====
`timescale 1ns / 1ps

module mhs_heading #(
    parameter int AFB = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  mhs_pkg::side_t             in_side,
    input  logic signed [AFB+8:0]      in_z,
    output logic                       out_valid,
    output logic [mhs_pkg::DEG_W-1:0]  out_heading
);

    localparam int ZW = AFB + 9;
    localparam int TW = AFB + 6;

    localparam logic signed [ZW-1:0] TOP_Z = ZW'(45) << AFB;
    localparam logic [TW-1:0]        TOP_T = TW'(45) << AFB;
    localparam logic [TW:0]          R90   = (TW + 1)'(90) << AFB;
    localparam logic [TW+1:0]        R180  = (TW + 2)'(180) << AFB;

    logic [TW-1:0]               t_next;
    logic [TW:0]                 m1;
    logic [TW+1:0]               m2;
    logic [7:0]                  ip;
    logic [mhs_pkg::DEG_W-1:0]   head_next;

    logic                        v1_reg;
    mhs_pkg::side_t              side1_reg;
    logic [TW-1:0]               t_reg;
    logic                        v2_reg;
    logic [mhs_pkg::DEG_W-1:0]   head_reg;

    // octant angle with exact edges and clamp to [0, 45]
    always_comb begin
        if (in_side.on_axis) begin
            t_next = '0;
        end else if (in_side.diag) begin
            t_next = TOP_T;
        end else if (in_z < 0) begin
            t_next = '0;
        end else if (in_z > TOP_Z) begin
            t_next = TOP_T;
        end else begin
            t_next = in_z[TW-1:0];
        end
    end

    // unfold to the half plane, keep the integer part, wrap below the axis
    always_comb begin
        m1 = side1_reg.swapped ? (R90 - {1'b0, t_reg}) : {1'b0, t_reg};
        m2 = side1_reg.neg_x ? (R180 - {1'b0, m1}) : {1'b0, m1};
        ip = m2[TW+1:AFB];
        if (side1_reg.zero) begin
            head_next = '0;
        end else if (side1_reg.neg_y && (ip != 8'd0)) begin
            head_next = mhs_pkg::HEADING_TURN - {1'b0, ip};
        end else begin
            head_next = {1'b0, ip};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg <= in_side;
            t_reg     <= t_next;
            head_reg  <= head_next;
        end
    end

    assign out_valid   = v2_reg;
    assign out_heading = head_reg;

endmodule

// ===== rtl/core/mhs_divider.sv =====
`timescale 1ns / 1ps

module mhs_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [mhs_pkg::DEG_W-1:0]  in_heading,
    input  logic [mhs_pkg::DEG_W-1:0]  section_width,
    input  logic [mhs_pkg::DEG_W-1:0]  safe_low,
    input  logic [mhs_pkg::DEG_W-1:0]  safe_high,
    output logic                       out_valid,
    output mhs_pkg::res_t              out_res
);

    localparam int DW = mhs_pkg::DEG_W;

    logic [DW-1:0] w_eff;
    logic          v_s [0:DW];
    logic [DW-1:0] h_s [0:DW];
    logic [DW-1:0] r_s [0:DW];
    logic [DW-1:0] q_s [0:DW];

    mhs_pkg::res_t res_next;
    mhs_pkg::res_t res_reg;
    logic          v_reg;

    // a zero width divides as one
    assign w_eff = (section_width == '0) ? DW'(1) : section_width;

    assign v_s[0] = in_valid;
    assign h_s[0] = in_heading;
    assign r_s[0] = '0;
    assign q_s[0] = '0;

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 0; k < DW; k++) begin : g_bit
        localparam int J = DW - 1 - k;

        logic [DW:0]   rem_try;
        logic          fits;
        logic [DW-1:0] r_next;
        logic          sv_reg;
        logic [DW-1:0] h_reg;
        logic [DW-1:0] r_reg;
        logic [DW-1:0] q_reg;

        assign rem_try = {r_s[k], h_s[k][J]};
        assign fits    = rem_try >= {1'b0, w_eff};
        assign r_next  = fits ? DW'(rem_try - {1'b0, w_eff}) : rem_try[DW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg <= 1'b0;
            end else if (adv) begin
                sv_reg <= v_s[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                h_reg <= h_s[k];
                r_reg <= r_next;
                q_reg <= {q_s[k][DW-2:0], fits};
            end
        end

        assign v_s[k+1] = sv_reg;
        assign h_s[k+1] = h_reg;
        assign r_s[k+1] = r_reg;
        assign q_s[k+1] = q_reg;
    end

    always_comb begin
        res_next.heading = h_s[DW];
        res_next.index   = q_s[DW];
        res_next.degree  = r_s[DW];
        res_next.safe    = (r_s[DW] > safe_low) && (r_s[DW] < safe_high);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= v_s[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/core/mhs_checker.sv =====
`timescale 1ns / 1ps

module mhs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // heading stays in range and the remainder never exceeds it
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:0] <= 9'd359) && (m_tdata[26:18] <= m_tdata[8:0]))
        else $error("heading or remainder out of range");

    // the safe flag needs a remainder above the low bound, so never zero
    a_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[26:18] != 9'd0)
        else $error("safe flag with zero remainder");

endmodule

bind magnetic_heading_sectorizer mhs_checker u_mhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/heading_checker.sv =====
`timescale 1ns / 1ps

module heading_checker #(
    parameter int         ANGLE_FRACTION_BITS = 16,
    parameter logic [3:0] WIDTH_ADDR          = 4'h0,
    parameter logic [3:0] LOW_ADDR            = 4'h4,
    parameter logic [3:0] HIGH_ADDR           = 4'h8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // mag_x [15:0], mag_y [31:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // heading_deg [8:0], section_index [17:9],
                                    // degree_in_section [26:18], section_safe [27]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding,
    output int          words_checked
);

    localparam int REPORT_LIMIT = 10;

    localparam logic [mhs_pkg::DEG_W-1:0] WIDTH_AT_RESET = 9'd20;
    localparam logic [mhs_pkg::DEG_W-1:0] LOW_AT_RESET   = 9'd6;
    localparam logic [mhs_pkg::DEG_W-1:0] HIGH_AT_RESET  = 9'd13;

    logic [mhs_pkg::DEG_W-1:0] section_width;
    logic [mhs_pkg::DEG_W-1:0] safe_low;
    logic [mhs_pkg::DEG_W-1:0] safe_high;

    mhs_pkg::res_t sector_q [$];
    mhs_pkg::res_t got;
    mhs_pkg::res_t want;

    // heading, section and safe flag of one reading under the current registers
    function automatic mhs_pkg::res_t sector_of_reading(input logic [31:0] word);
        longint        mx, my, a, b, swap_tmp;
        longint        x, y, z, xs, ys, step_angle, octant_top;
        longint        t, m, heading, w;
        longint        quo, rem;
        int            steps, i, drop;
        logic          swapped;
        mhs_pkg::res_t res;
        mx = $signed(word[15:0]);
        my = $signed(word[31:16]);
        a  = (mx < 0) ? -mx : mx;
        b  = (my < 0) ? -my : my;
        octant_top = longint'(45) <<< ANGLE_FRACTION_BITS;
        if (a == 0 && b == 0) begin
            heading = 0;
        end else begin
            swapped = 1'b0;
            if (b > a) begin
                swap_tmp = a;
                a        = b;
                b        = swap_tmp;
                swapped  = 1'b1;
            end
            if (b == 0) begin
                t = 0;
            end else if (b == a) begin
                t = octant_top;
            end else begin
                // vectoring cordic on the folded reading
                x     = a <<< mhs_pkg::PRE_SHIFT;
                y     = b <<< mhs_pkg::PRE_SHIFT;
                z     = 0;
                steps = ANGLE_FRACTION_BITS + 4;
                if (steps > mhs_pkg::TABLE_LEN) begin
                    steps = mhs_pkg::TABLE_LEN;
                end
                drop = mhs_pkg::TABLE_BITS - ANGLE_FRACTION_BITS;
                for (i = 0; i < steps; i++) begin
                    step_angle = longint'(mhs_pkg::ATAN_Q24[i]);
                    if (drop > 0) begin
                        step_angle = ((step_angle >>> (drop - 1)) + 1) >>> 1;
                    end
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + step_angle;
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - step_angle;
                    end
                end
                if (z < 0) begin
                    z = 0;
                end
                if (z > octant_top) begin
                    z = octant_top;
                end
                t = z;
            end
            m = swapped ? ((longint'(90) <<< ANGLE_FRACTION_BITS) - t) : t;
            if (mx < 0) begin
                m = (longint'(180) <<< ANGLE_FRACTION_BITS) - m;
            end
            heading = m >>> ANGLE_FRACTION_BITS;
            if (my < 0 && heading != 0) begin
                heading = 360 - heading;
            end
        end
        w = (section_width == '0) ? 1 : longint'(section_width);
        quo = heading / w;
        rem = heading % w;
        res.heading = heading[8:0];
        res.index   = quo[8:0];
        res.degree  = rem[8:0];
        res.safe    = (rem > longint'(safe_low)) && (rem < longint'(safe_high));
        return res;
    endfunction

    task automatic log_failure(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            section_width = WIDTH_AT_RESET;
            safe_low      = LOW_AT_RESET;
            safe_high     = HIGH_AT_RESET;
            sector_q.delete();
            mismatches    = 0;
            words_checked = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    WIDTH_ADDR: section_width = pwdata[8:0];
                    LOW_ADDR:   safe_low      = pwdata[8:0];
                    HIGH_ADDR:  safe_high     = pwdata[8:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                sector_q.push_back(sector_of_reading(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                if (sector_q.size() == 0) begin
                    log_failure($sformatf(
                        "unexpected word: heading %0d index %0d degree %0d safe %0b",
                        got.heading, got.index, got.degree, got.safe));
                end else begin
                    want = sector_q.pop_front();
                    if (got.heading !== want.heading || got.index !== want.index ||
                        got.degree !== want.degree || got.safe !== want.safe) begin
                        log_failure($sformatf({"word %0d mismatch: expected heading %0d ",
                            "index %0d degree %0d safe %0b, got heading %0d index %0d ",
                            "degree %0d safe %0b"}, words_checked,
                            want.heading, want.index, want.degree, want.safe,
                            got.heading, got.index, got.degree, got.safe));
                    end
                end
                words_checked++;
            end
        end
        outstanding = sector_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int ANGLE_FRACTION_BITS = 16;
    // pipeline depth: fold and cordic stages plus heading, divider and output stages
    localparam int CORDIC_STAGES = (ANGLE_FRACTION_BITS + 4 > mhs_pkg::TABLE_LEN) ?
                                   mhs_pkg::TABLE_LEN : ANGLE_FRACTION_BITS + 4;
    localparam int LATENCY = CORDIC_STAGES + 14;

    // register byte addresses
    localparam logic [3:0] ADDR_SECTION_WIDTH = 4'h0;
    localparam logic [3:0] ADDR_SAFE_LOW      = 4'h4;
    localparam logic [3:0] ADDR_SAFE_HIGH     = 4'h8;

    localparam int FIXED_SETTINGS  = 6;
    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 213;
    localparam int STEADY_PHASE    = 1;    // neither side idles here
    localparam int HOLD_PHASE      = 2;    // first long receiver stall
    localparam int IDLE_PERCENT    = 21;   // receiver idle cycles in a hundred
    localparam int TX_GAP_PERCENT  = 26;   // one-cycle sender gaps, about 21 idle in a hundred
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [8:0] width;
        logic [8:0] low;
        logic [8:0] high;
    } sector_setting_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // mag_x [15:0], mag_y [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // heading_deg [8:0], section_index [17:9],
                                    // degree_in_section [26:18], section_safe [27]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int words_checked;
    int cycle_count = 0;
    int words_sent  = 0;

    // pacing controls shared with the result sink
    bit tx_steady       = 1'b0;
    bit rx_steady       = 1'b0;
    bit rx_hold_request = 1'b0;

    // readings at the ends of the 16-bit range and around zero
    int axis_extremes [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    // register settings: one-degree sections, a whole turn, width zero,
    // width past the turn, inverted bounds, bounds that never pass
    sector_setting_t fixed_settings [FIXED_SETTINGS] = '{
        '{9'd1,   9'd0,   9'd360},
        '{9'd360, 9'd0,   9'd359},
        '{9'd0,   9'd0,   9'd1},
        '{9'd511, 9'd100, 9'd511},
        '{9'd45,  9'd44,  9'd2},
        '{9'd7,   9'd0,   9'd0}
    };

    // directed readings, each word is {mag_y, mag_x}
    logic [31:0] directed_readings [22] = '{
        {16'h0000, 16'h0000},   // zero vector
        {16'h0000, 16'h7FFF},   // positive x axis
        {16'h0000, 16'h8000},   // most negative x, on axis
        {16'h7FFF, 16'h0000},   // positive y axis
        {16'h8000, 16'h0000},   // most negative y, on axis
        {16'h7FFF, 16'h7FFF},   // exact diagonal
        {16'h8000, 16'h8000},   // exact diagonal, both negative
        {16'h7FFF, 16'h8000},
        {16'h8000, 16'h7FFF},
        {16'hFFFF, 16'h0001},   // small diagonal below the x axis
        {16'h0000, 16'hFFFF},
        {16'hFFFF, 16'h7FFF},   // negative angle under one degree
        {16'hFFEF, 16'h03E8},   // just under one degree below the axis
        {16'h0001, 16'h8000},   // just above the negative x axis
        {16'hFFFF, 16'h8000},   // just below the negative x axis
        {16'h0001, 16'h0000},
        {16'hFFFF, 16'h0000},
        {16'h0004, 16'h0003},
        {16'hFFFC, 16'hFFFD},
        {16'h8001, 16'h7FFF},
        {16'h0001, 16'hFFFF},
        {16'hFFF7, 16'h0005}
    };

    // clock, 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    magnetic_heading_sectorizer #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches both streams and the register port, predicts and compares
    heading_checker #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
        .WIDTH_ADDR         (ADDR_SECTION_WIDTH),
        .LOW_ADDR           (ADDR_SAFE_LOW),
        .HIGH_ADDR          (ADDR_SAFE_HIGH)
    ) heading_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .words_checked(words_checked)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, outstanding);
            $display("FAIL");
            $finish;
        end
    end

    // back-to-back writes of all three registers, called only while idle;
    // psel stays high between writes, upper data bits carry noise
    task automatic load_sectors(input sector_setting_t setting);
        logic [3:0] addr  [3];
        logic [8:0] value [3];
        int         k;
        addr  = '{ADDR_SECTION_WIDTH, ADDR_SAFE_LOW, ADDR_SAFE_HIGH};
        value = '{setting.width, setting.low, setting.high};
        for (k = 0; k < 3; k++) begin
            // setup cycle
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr[k];
            pwdata  <= ($urandom() & 32'hFFFF_FE00) | {23'd0, value[k]};
            @(posedge aclk);
            // access cycle, register takes the word at the next edge
            penable <= 1'b1;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one reading and return at the edge where it is taken;
    // s_tready is looked at on the falling edge, where it is settled
    task automatic offer_reading(input logic [31:0] word);
        if (!tx_steady && $urandom_range(0, 99) < TX_GAP_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        words_sent++;
    endtask

    // sender pause until every predicted word has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // result sink: random backpressure, a steady stretch and long holds
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (rx_hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold_request = 1'b0;
            end
            m_tready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial begin : stimulus
        sector_setting_t setting;
        logic [31:0]     rnd;
        int              sx, sy;
        int              phase, n, d;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words under the register values after reset
        for (d = 0; d < $size(directed_readings); d++) begin
            offer_reading(directed_readings[d]);
        end
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < FIXED_SETTINGS) begin
                setting = fixed_settings[phase];
            end else begin
                setting.width = 9'($urandom_range(1, 360));
                setting.low   = 9'($urandom_range(0, setting.width));
                setting.high  = 9'($urandom_range(setting.low, 360));
            end
            load_sectors(setting);
            tx_steady = (phase == STEADY_PHASE);
            rx_steady = tx_steady;
            // long stalls: the pipeline fills and s_tready must drop
            if (phase == HOLD_PHASE || phase == PHASES - 1) begin
                rx_hold_request = 1'b1;
            end

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                rnd = $urandom();
                sx  = int'($signed(rnd[15:0]));
                sy  = int'($signed(rnd[31:16]));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ;   // uniform over the full range
                    4: begin        // tiny vectors, many on axes and diagonals
                        sx = int'($urandom_range(0, 8)) - 4;
                        sy = int'($urandom_range(0, 8)) - 4;
                    end
                    5: begin        // close to an axis
                        if (rnd[0]) begin
                            sy = int'($urandom_range(0, 2)) - 1;
                        end else begin
                            sx = int'($urandom_range(0, 2)) - 1;
                        end
                    end
                    6: begin        // on or next to a diagonal, octant fold edge
                        sy = (rnd[1] ? sx : -sx) + int'($urandom_range(0, 2)) - 1;
                    end
                    7: begin        // range extremes
                        sx = axis_extremes[$urandom_range(0, 6)];
                        sy = axis_extremes[$urandom_range(0, 6)];
                    end
                    default: begin  // random magnitudes
                        sx = sx >>> $urandom_range(0, 14);
                        sy = sy >>> $urandom_range(0, 14);
                    end
                endcase
                offer_reading({sy[15:0], sx[15:0]});
            end
            drain_results();
        end

        // let anything stray reach the output
        repeat (LATENCY + 8) @(posedge aclk);
        $display("covered %0d readings, %0d words checked, over %0d register settings",
                 words_sent, words_checked, PHASES + 1);
        $display("settings took in width zero, width past a turn, inverted bounds, two stalls");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mhs_pkg.sv
rtl/core/mhs_fold.sv
rtl/core/mhs_cordic.sv
rtl/core/mhs_heading.sv
rtl/core/mhs_divider.sv
rtl/core/magnetic_heading_sectorizer.sv
rtl/core/mhs_checker.sv
tb/heading_checker.sv
tb/testbench.sv
